// File: hw/rtl/fasd_pkg.sv
// Package for the firing angle soft start / dither block.
// Holds widths, reset values, codes, the shared structs and the angle helpers.
// No dependencies.
package fasd_pkg;

    localparam int ANGLE_W  = 8;
    localparam int STEP_W   = 7;
    localparam int PERIOD_W = 16;
    localparam int DELAY_W  = 4;
    localparam int CALC_W   = 12;

    localparam logic [ANGLE_W-1:0]  MAX_ANGLE = 8'd180;
    localparam logic [PERIOD_W-1:0] TICK_MS   = 16'd10;

    // Firing delay is angle / 18, done as angle * 57 >> 10 (exact for 0..180)
    localparam int DELAY_RECIP = 57;
    localparam int DELAY_RSH   = 10;
    localparam int PROD_W      = 14;

    // Register reset values
    localparam logic [ANGLE_W-1:0]  STARTUP_RESET       = 8'd170;
    localparam logic [ANGLE_W-1:0]  LOW_RESET           = 8'd150;
    localparam logic [ANGLE_W-1:0]  MID_RESET           = 8'd90;
    localparam logic [ANGLE_W-1:0]  HIGH_RESET          = 8'd30;
    localparam logic [STEP_W-1:0]   RAMP_STEP_RESET     = 7'd5;
    localparam logic [STEP_W-1:0]   DITHER_SHIFT_RESET  = 7'd5;
    localparam logic [PERIOD_W-1:0] RAMP_PERIOD_RESET   = 16'd100;
    localparam logic [PERIOD_W-1:0] DITHER_PERIOD_RESET = 16'd100;

    // Register indexes (byte address = 4 * index)
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = 5;
    localparam logic [REG_IDX_W-1:0] REG_STARTUP       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOW_SPEED     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MID_SPEED     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_SPEED    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RAMP_STEP     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DITHER_SHIFT  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RAMP_PERIOD   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_DITHER_PERIOD = 3'd7;

    // Item codes
    localparam logic       CMD_TICK  = 1'b0;
    localparam logic       CMD_SPEED = 1'b1;
    localparam logic [1:0] SPD_LOW   = 2'd0;
    localparam logic [1:0] SPD_MID   = 2'd1;
    localparam logic [1:0] SPD_HIGH  = 2'd2;
    localparam logic       MODE_RAMP   = 1'b0;
    localparam logic       MODE_DITHER = 1'b1;

    typedef struct packed {
        logic [ANGLE_W-1:0]  low_target;
        logic [ANGLE_W-1:0]  mid_target;
        logic [ANGLE_W-1:0]  high_target;
        logic [STEP_W-1:0]   ramp_step;
        logic [STEP_W-1:0]   dither_shift;
        logic [PERIOD_W-1:0] ramp_period;
        logic [PERIOD_W-1:0] dither_period;
    } cfg_t;

    typedef struct packed {
        logic       command;
        logic [1:0] speed_select;
    } item_t;

    typedef struct packed {
        logic [DELAY_W-1:0] firing_delay_ms;
        logic               mode;
        logic [ANGLE_W-1:0] firing_angle;
    } result_t;

    // Saturate a signed working value to 0..180
    function automatic logic [ANGLE_W-1:0] cap_angle(input logic signed [CALC_W-1:0] a);
        logic [ANGLE_W-1:0] r;
        if (a < 0) begin
            r = '0;
        end else if (a > $signed({{(CALC_W-ANGLE_W){1'b0}}, MAX_ANGLE})) begin
            r = MAX_ANGLE;
        end else begin
            r = a[ANGLE_W-1:0];
        end
        return r;
    endfunction

    // Widen an unsigned angle or step to the signed working width
    function automatic logic signed [CALC_W-1:0] to_calc(input logic [ANGLE_W-1:0] a);
        return $signed({{(CALC_W-ANGLE_W){1'b0}}, a});
    endfunction

    // Firing delay in ms: angle / 18 by reciprocal multiply
    function automatic logic [DELAY_W-1:0] delay_of(input logic [ANGLE_W-1:0] a);
        logic [PROD_W-1:0] prod;
        prod = {{(PROD_W-ANGLE_W){1'b0}}, a} * PROD_W'(DELAY_RECIP);
        return prod[DELAY_RSH +: DELAY_W];
    endfunction

endpackage

// File: hw/rtl/firing_angle_soft_start_dither_core.sv
// Top level of the phase-angle firing controller with soft start and dither.
// Instantiates fasd_regs and fasd_ctrl; uses fasd_pkg.
//
// Each input beat is a tick (s_tuser = 0) or a speed selection (s_tuser = 1,
// speed code in s_tdata) and yields exactly one result beat carrying angle,
// mode and firing delay. The block takes one beat per clock cycle while the
// result side is not stalled; each beat is held in the input register, then
// passes through the single-pass state update into the result register once
// that register is free.
// Both sides may stall freely. Write the configuration registers only while
// no beats are in flight; startup_angle is read back but the angle after
// reset is always the reset value of that register.
module firing_angle_soft_start_dither_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fasd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [1:0] speed_select, [7:2] zero
    input  logic                        s_tuser,   // [0] command
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata    // [7:0] firing_angle, [8] mode,
                                                   // [12:9] firing_delay_ms, [15:13] zero
);
    import fasd_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_res_reg;
    result_t step_res;
    logic    out_valid_reg;
    logic    out_adv;
    logic    fire;

    fasd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fasd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (fire),
        .item    (in_item_reg),
        .result  (step_res)
    );

    // Pipeline handshake: output register frees when empty or taken
    assign out_adv  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;

    // Input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.command      <= s_tuser;
            in_item_reg.speed_select <= s_tdata[1:0];
        end
    end

    // Result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Result register payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_res_reg.firing_delay_ms, out_res_reg.mode,
                       out_res_reg.firing_angle};

endmodule

// File: hw/rtl/fasd_regs.sv
// APB configuration registers of the firing angle block.
// Write at psel & penable & pwrite, combinational read-back. Uses fasd_pkg.
module fasd_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fasd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output fasd_pkg::cfg_t              cfg
);
    import fasd_pkg::*;

    logic [ANGLE_W-1:0]  startup_reg;
    cfg_t                cfg_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            startup_reg           <= STARTUP_RESET;
            cfg_reg.low_target    <= LOW_RESET;
            cfg_reg.mid_target    <= MID_RESET;
            cfg_reg.high_target   <= HIGH_RESET;
            cfg_reg.ramp_step     <= RAMP_STEP_RESET;
            cfg_reg.dither_shift  <= DITHER_SHIFT_RESET;
            cfg_reg.ramp_period   <= RAMP_PERIOD_RESET;
            cfg_reg.dither_period <= DITHER_PERIOD_RESET;
        end else if (wr_en) begin
            case (idx)
                REG_STARTUP:       startup_reg           <= pwdata[ANGLE_W-1:0];
                REG_LOW_SPEED:     cfg_reg.low_target    <= pwdata[ANGLE_W-1:0];
                REG_MID_SPEED:     cfg_reg.mid_target    <= pwdata[ANGLE_W-1:0];
                REG_HIGH_SPEED:    cfg_reg.high_target   <= pwdata[ANGLE_W-1:0];
                REG_RAMP_STEP:     cfg_reg.ramp_step     <= pwdata[STEP_W-1:0];
                REG_DITHER_SHIFT:  cfg_reg.dither_shift  <= pwdata[STEP_W-1:0];
                REG_RAMP_PERIOD:   cfg_reg.ramp_period   <= pwdata[PERIOD_W-1:0];
                REG_DITHER_PERIOD: cfg_reg.dither_period <= pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        case (idx)
            REG_STARTUP:       prdata = {24'd0, startup_reg};
            REG_LOW_SPEED:     prdata = {24'd0, cfg_reg.low_target};
            REG_MID_SPEED:     prdata = {24'd0, cfg_reg.mid_target};
            REG_HIGH_SPEED:    prdata = {24'd0, cfg_reg.high_target};
            REG_RAMP_STEP:     prdata = {25'd0, cfg_reg.ramp_step};
            REG_DITHER_SHIFT:  prdata = {25'd0, cfg_reg.dither_shift};
            REG_RAMP_PERIOD:   prdata = {16'd0, cfg_reg.ramp_period};
            REG_DITHER_PERIOD: prdata = {16'd0, cfg_reg.dither_period};
            default:           prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/fasd_ctrl.sv
// Angle state and per-item update of the firing angle block.
// Holds current/target angle, mode and both period counters. Uses fasd_pkg.
module fasd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  fasd_pkg::cfg_t    cfg,
    input  logic              fire,
    input  fasd_pkg::item_t   item,
    output fasd_pkg::result_t result
);
    import fasd_pkg::*;

    logic [ANGLE_W-1:0]  cur_reg, cur_next;
    logic [ANGLE_W-1:0]  tgt_reg, tgt_next;
    logic                mode_reg, mode_next;
    logic [PERIOD_W-1:0] rc_reg, rc_next;
    logic [PERIOD_W-1:0] dc_reg, dc_next;

    logic signed [CALC_W-1:0] cur_s, tgt_s, sh_s, st_s, band_lo, band_hi;
    logic [PERIOD_W-1:0]      rc_sum, dc_sum;

    assign cur_s   = to_calc(cur_reg);
    assign tgt_s   = to_calc(tgt_reg);
    assign sh_s    = to_calc({1'b0, cfg.dither_shift});
    assign st_s    = to_calc({1'b0, cfg.ramp_step});
    assign band_lo = tgt_s - sh_s;
    assign band_hi = tgt_s + sh_s;
    assign rc_sum  = rc_reg + TICK_MS;
    assign dc_sum  = dc_reg + TICK_MS;

    // Next state for the item leaving the input register
    always_comb begin
        cur_next  = cur_reg;
        tgt_next  = tgt_reg;
        mode_next = mode_reg;
        rc_next   = rc_reg;
        dc_next   = dc_reg;
        if (fire) begin
            if (item.command == CMD_SPEED) begin
                // Unknown speed code keeps the target
                case (item.speed_select)
                    SPD_LOW:  tgt_next = cap_angle(to_calc(cfg.low_target));
                    SPD_MID:  tgt_next = cap_angle(to_calc(cfg.mid_target));
                    SPD_HIGH: tgt_next = cap_angle(to_calc(cfg.high_target));
                    default:  tgt_next = tgt_reg;
                endcase
            end else if (mode_reg == MODE_RAMP) begin
                // Inside closed band: switch to dither, else advance the ramp
                if (cur_s >= band_lo && cur_s <= band_hi) begin
                    mode_next = MODE_DITHER;
                end else begin
                    rc_next = rc_sum;
                    if (rc_sum == cfg.ramp_period) begin
                        cur_next = cap_angle((cur_s > tgt_s) ? (cur_s - st_s) : (cur_s + st_s));
                        rc_next  = '0;
                    end
                end
            end else begin
                // Outside open band: back to ramp, else advance the dither
                if (cur_s >= band_hi || cur_s <= band_lo) begin
                    mode_next = MODE_RAMP;
                end else begin
                    dc_next = dc_sum;
                    if (dc_sum == cfg.dither_period) begin
                        if (cur_s == tgt_s) begin
                            cur_next = cap_angle(cur_s + sh_s);
                        end else if (cur_s > tgt_s) begin
                            cur_next = cap_angle(cur_s - (sh_s <<< 1));
                        end else begin
                            cur_next = cap_angle(cur_s + (sh_s <<< 1));
                        end
                        dc_next = '0;
                    end
                end
            end
        end
    end

    // Result of this item, taken into the output register by the top level
    assign result.firing_angle    = cur_next;
    assign result.mode            = mode_next;
    assign result.firing_delay_ms = delay_of(cur_next);

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= cap_angle(to_calc(STARTUP_RESET));
            tgt_reg  <= cap_angle(to_calc(MID_RESET));
            mode_reg <= MODE_RAMP;
            rc_reg   <= '0;
            dc_reg   <= '0;
        end else begin
            cur_reg  <= cur_next;
            tgt_reg  <= tgt_next;
            mode_reg <= mode_next;
            rc_reg   <= rc_next;
            dc_reg   <= dc_next;
        end
    end

endmodule

// File: tb/sv/firing_result_checker.sv
`timescale 1ns / 1ps
// Result checker for firing_angle_soft_start_dither_core: follows the APB writes
// and both streams, predicts every result beat and compares it. Uses fasd_pkg.
module firing_result_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [fasd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [1:0] speed_select, [7:2] zero
    input  logic                        s_tuser,   // [0] command
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [15:0]                 m_tdata,   // [7:0] firing_angle, [8] mode,
                                                   // [12:9] firing_delay_ms, [15:13] zero
    output int                          mismatch_count,
    output int                          results_pending
);
    import fasd_pkg::*;

    localparam int DELAY_DIV  = 18;
    localparam int REPORT_MAX = 10;

    // Shadow copy of the registers that steer the angle
    logic [ANGLE_W-1:0]  low_angle, mid_angle, high_angle;
    logic [STEP_W-1:0]   step_size, shift_size;
    logic [PERIOD_W-1:0] ramp_len, dither_len;

    // Predicted controller state
    logic [ANGLE_W-1:0]  angle_now, angle_goal;
    logic                mode_now;
    logic [PERIOD_W-1:0] ramp_ms, dither_ms;

    result_t angle_results_due[$];
    int      failures;

    function automatic logic [ANGLE_W-1:0] clamp_angle(input int a);
        if (a < 0) return '0;
        if (a > int'(MAX_ANGLE)) return MAX_ANGLE;
        return a[ANGLE_W-1:0];
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= REPORT_MAX) $display("[%0t] %s", $realtime, msg);
    endtask

    // One input beat: either pick a new target or run one control tick
    task automatic advance_controller(input logic cmd, input logic [1:0] sel,
                                      output result_t res);
        int cur, tgt, sh, st;
        cur = int'(angle_now);
        tgt = int'(angle_goal);
        sh  = int'(shift_size);
        st  = int'(step_size);
        if (cmd == CMD_SPEED) begin
            case (sel)
                SPD_LOW:  angle_goal = clamp_angle(int'(low_angle));
                SPD_MID:  angle_goal = clamp_angle(int'(mid_angle));
                SPD_HIGH: angle_goal = clamp_angle(int'(high_angle));
                default: ; // unknown code keeps the target
            endcase
        end else if (mode_now == MODE_RAMP) begin
            // band edges are not clipped to the angle range
            if (cur >= tgt - sh && cur <= tgt + sh) begin
                mode_now = MODE_DITHER;
            end else begin
                ramp_ms = ramp_ms + TICK_MS;
                if (ramp_ms == ramp_len) begin
                    angle_now = clamp_angle(cur > tgt ? cur - st : cur + st);
                    ramp_ms   = '0;
                end
            end
        end else begin
            if (cur >= tgt + sh || cur <= tgt - sh) begin
                mode_now = MODE_RAMP;
            end else begin
                dither_ms = dither_ms + TICK_MS;
                if (dither_ms == dither_len) begin
                    if (cur == tgt)     angle_now = clamp_angle(cur + sh);
                    else if (cur > tgt) angle_now = clamp_angle(cur - 2 * sh);
                    else                angle_now = clamp_angle(cur + 2 * sh);
                    dither_ms = '0;
                end
            end
        end
        res.firing_angle    = angle_now;
        res.mode            = mode_now;
        res.firing_delay_ms = DELAY_W'(int'(angle_now) / DELAY_DIV);
    endtask

    always @(posedge aclk) begin
        result_t due, seen;
        if (!aresetn) begin
            low_angle  = LOW_RESET;
            mid_angle  = MID_RESET;
            high_angle = HIGH_RESET;
            step_size  = RAMP_STEP_RESET;
            shift_size = DITHER_SHIFT_RESET;
            ramp_len   = RAMP_PERIOD_RESET;
            dither_len = DITHER_PERIOD_RESET;
            angle_now  = clamp_angle(int'(STARTUP_RESET));
            angle_goal = clamp_angle(int'(MID_RESET));
            mode_now   = MODE_RAMP;
            ramp_ms    = '0;
            dither_ms  = '0;
            angle_results_due.delete();
        end else begin
            // Track register writes; the startup angle only matters at reset
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_STARTUP:       ;
                    REG_LOW_SPEED:     low_angle  = pwdata[ANGLE_W-1:0];
                    REG_MID_SPEED:     mid_angle  = pwdata[ANGLE_W-1:0];
                    REG_HIGH_SPEED:    high_angle = pwdata[ANGLE_W-1:0];
                    REG_RAMP_STEP:     step_size  = pwdata[STEP_W-1:0];
                    REG_DITHER_SHIFT:  shift_size = pwdata[STEP_W-1:0];
                    REG_RAMP_PERIOD:   ramp_len   = pwdata[PERIOD_W-1:0];
                    REG_DITHER_PERIOD: dither_len = pwdata[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            // Predict on every accepted input beat
            if (s_tvalid && s_tready) begin
                advance_controller(s_tuser, s_tdata[1:0], due);
                angle_results_due.push_back(due);
            end
            // Compare every accepted result beat with the oldest prediction
            if (m_tvalid && m_tready) begin
                seen = result_t'(m_tdata[12:0]);
                if (angle_results_due.size() == 0) begin
                    note_failure($sformatf("unexpected result: angle %0d mode %0d delay %0d",
                                           seen.firing_angle, seen.mode,
                                           seen.firing_delay_ms));
                end else begin
                    due = angle_results_due.pop_front();
                    if (seen.firing_angle !== due.firing_angle || seen.mode !== due.mode ||
                        seen.firing_delay_ms !== due.firing_delay_ms) begin
                        note_failure($sformatf(
                            "result mismatch: exp angle %0d mode %0d delay %0d, got %0d %0d %0d",
                            due.firing_angle, due.mode, due.firing_delay_ms,
                            seen.firing_angle, seen.mode, seen.firing_delay_ms));
                    end
                end
            end
        end
        results_pending <= angle_results_due.size();
        mismatch_count  <= failures;
    end

endmodule

// File: tb/sv/tb_firing_angle_soft_start_dither_core.sv
`timescale 1ns / 1ps
// Top of the testbench for firing_angle_soft_start_dither_core: clock, reset,
// register setup and beat traffic. Uses fasd_pkg and firing_result_checker.
module tb_firing_angle_soft_start_dither_core;
    import fasd_pkg::*;

    localparam logic [1:0] SPD_NONE    = 2'd3;
    localparam int         CYCLE_LIMIT = 200_000;
    localparam int         PHASES      = 8;
    localparam int         PHASE_BEATS = 90;

    logic              aclk;
    logic              aresetn;
    logic              psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_tvalid, s_tready;
    logic [7:0]        s_tdata;   // [1:0] speed_select, [7:2] zero
    logic              s_tuser;   // [0] command
    logic              m_tvalid, m_tready;
    logic [15:0]       m_tdata;   // [7:0] firing_angle, [8] mode, [12:9] firing_delay_ms
    int                mismatch_count;
    int                results_pending;
    bit                no_idle;

    firing_angle_soft_start_dither_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    firing_result_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .mismatch_count(mismatch_count), .results_pending(results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        int n;
        for (n = 0; n < CYCLE_LIMIT; n++) @(posedge aclk);
        $display("tb_firing_angle_soft_start_dither_core: errors");
        $finish;
    end

    // Result side: stall a random number of cycles before each beat
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // One APB write, after which the bus is left idle before it is used again
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_all(input int startup, input int low, input int mid, input int high,
                             input int step, input int shift, input int rlen, input int dlen);
        write_reg(REG_STARTUP, startup);
        write_reg(REG_LOW_SPEED, low);
        write_reg(REG_MID_SPEED, mid);
        write_reg(REG_HIGH_SPEED, high);
        write_reg(REG_RAMP_STEP, step);
        write_reg(REG_DITHER_SHIFT, shift);
        write_reg(REG_RAMP_PERIOD, rlen);
        write_reg(REG_DITHER_PERIOD, dlen);
    endtask

    function automatic int pick_angle();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(181, 255) : $urandom_range(0, 180);
    endfunction

    function automatic int pick_step(input int hi);
        if ($urandom_range(0, 5) == 0) return $urandom_range(0, 1) ? 127 : 0;
        return $urandom_range(1, hi);
    endfunction

    function automatic int pick_period();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
        return 10 * $urandom_range(1, 6);
    endfunction

    // Present one beat after a random gap and hold it until taken
    task automatic send_item(input logic cmd, input logic [1:0] sel);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, sel};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic run_ticks(input int n);
        repeat (n) send_item(CMD_TICK, 2'($urandom_range(0, 3)));
    endtask

    // Hold the input side until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    initial begin
        int p, i;
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_TICK;
        no_idle  = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: each selection, unknown code, saturation at both ends,
        // entering and leaving the dither band
        write_all(0, 255, 90, 0, 90, 7, 10, 10);
        send_item(CMD_SPEED, SPD_LOW);
        run_ticks(4);
        send_item(CMD_SPEED, SPD_NONE);
        run_ticks(2);
        send_item(CMD_SPEED, SPD_HIGH);
        run_ticks(5);
        send_item(CMD_SPEED, SPD_MID);
        run_ticks(6);
        send_item(CMD_TICK, SPD_NONE);
        drain();

        // Random phases, the first ones at the register extremes
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: write_all(0, 0, 0, 0, 0, 0, 0, 0);
                1: write_all(255, 255, 255, 255, 127, 127, 65535, 65535);
                2: write_all(180, 180, 0, 180, 90, 90, 10, 10);
                3: write_all(170, 150, 90, 30, 5, 5, 100, 100);
                default: write_all(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                                   pick_step(40), pick_step(30), pick_period(),
                                   pick_period());
            endcase
            for (i = 0; i < PHASE_BEATS; i++) begin
                if ($urandom_range(0, 39) == 0) drain();
                if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
                if ($urandom_range(0, 6) == 0) send_item(CMD_SPEED, 2'($urandom_range(0, 3)));
                else send_item(CMD_TICK, 2'($urandom_range(0, 3)));
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_firing_angle_soft_start_dither_core: clean");
        end else begin
            $display("tb_firing_angle_soft_start_dither_core: errors");
        end
        $finish;
    end

endmodule
